FILE: hdl/c2p_pkg.sv
// shared types and constants for the cartesian to polar converter
package c2p_pkg;

    localparam int N_ITER = 32;
    localparam int CW     = 63;
    localparam int ZW     = 32;
    localparam int TW     = 31;
    localparam int CSCALE = 61;

    localparam logic [TW-1:0] TURN_QUARTER = TW'(32'h4000_0000);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ZW-1:0] ATAN_TAB [0:N_ITER-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic xn;
        logic yn;
        logic orig;
    } quad_t;

endpackage

FILE: hdl/c2p_prep.sv
// front stages: quadrant fold, squares and sum, cordic seed
module c2p_prep #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_vld,
    input  logic signed [COORD_BITS-1:0]     x_in,
    input  logic signed [COORD_BITS-1:0]     y_in,
    output logic                             vld_out,
    output c2p_pkg::quad_t                   flags_out,
    output logic [2*COORD_BITS-1:0]          n_out,
    output logic signed [c2p_pkg::CW-1:0]    cx_out,
    output logic signed [c2p_pkg::CW-1:0]    cy_out
);
    import c2p_pkg::*;

    localparam int SH = CSCALE - COORD_BITS;
    localparam int NW = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] xu;
    logic [COORD_BITS-1:0] yu;
    logic                  vld1_reg;
    logic                  vld2_reg;
    logic                  vld3_reg;
    quad_t                 flags1_reg;
    quad_t                 flags2_reg;
    quad_t                 flags3_reg;
    quad_t                 flags1_next;
    logic [COORD_BITS-1:0] ax1_reg;
    logic [COORD_BITS-1:0] ay1_reg;
    logic [COORD_BITS-1:0] ax1_next;
    logic [COORD_BITS-1:0] ay1_next;
    logic [COORD_BITS-1:0] ax2_reg;
    logic [COORD_BITS-1:0] ay2_reg;
    logic [NW-1:0]         sqx_reg;
    logic [NW-1:0]         sqy_reg;
    logic [NW-1:0]         n_reg;
    logic [CW-1:0]         cx_reg;
    logic [CW-1:0]         cy_reg;
    logic [NW-1:0]         ax_ext;
    logic [NW-1:0]         ay_ext;

    // fold into first quadrant
    always_comb
    begin
        xu               = x_in;
        yu               = y_in;
        flags1_next.xn   = xu[COORD_BITS-1];
        flags1_next.yn   = yu[COORD_BITS-1];
        flags1_next.orig = (xu == '0) && (yu == '0);
        ax1_next         = flags1_next.xn ? (~xu + 1'b1) : xu;
        ay1_next         = flags1_next.yn ? (~yu + 1'b1) : yu;
        ax_ext           = NW'(ax1_reg);
        ay_ext           = NW'(ay1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags1_reg <= flags1_next;
            ax1_reg    <= ax1_next;
            ay1_reg    <= ay1_next;
            flags2_reg <= flags1_reg;
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            sqx_reg    <= ax_ext * ax_ext;
            sqy_reg    <= ay_ext * ay_ext;
            flags3_reg <= flags2_reg;
            n_reg      <= sqx_reg + sqy_reg;
            cx_reg     <= CW'(ax2_reg) << SH;
            cy_reg     <= CW'(ay2_reg) << SH;
        end
    end

    assign vld_out   = vld3_reg;
    assign flags_out = flags3_reg;
    assign n_out     = n_reg;
    assign cx_out    = cx_reg;
    assign cy_out    = cy_reg;

endmodule

FILE: hdl/c2p_cell.sv
// one cordic vectoring step plus, when IDX is below COORD_BITS, one square root digit
module c2p_cell #(
    parameter int COORD_BITS = 16,
    parameter int IDX        = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             vld_in,
    input  c2p_pkg::quad_t                   flags_in,
    input  logic signed [c2p_pkg::CW-1:0]    cx_in,
    input  logic signed [c2p_pkg::CW-1:0]    cy_in,
    input  logic signed [c2p_pkg::ZW-1:0]    z_in,
    input  logic [2*COORD_BITS-1:0]          rem_in,
    input  logic [COORD_BITS-1:0]            root_in,
    output logic                             vld_out,
    output c2p_pkg::quad_t                   flags_out,
    output logic signed [c2p_pkg::CW-1:0]    cx_out,
    output logic signed [c2p_pkg::CW-1:0]    cy_out,
    output logic signed [c2p_pkg::ZW-1:0]    z_out,
    output logic [2*COORD_BITS-1:0]          rem_out,
    output logic [COORD_BITS-1:0]            root_out
);
    import c2p_pkg::*;

    localparam int NW = 2 * COORD_BITS;
    localparam logic signed [ZW-1:0] ATAN_STEP = ATAN_TAB[IDX];

    logic                  vld_reg;
    quad_t                 flags_reg;
    logic signed [CW-1:0]  cx_reg;
    logic signed [CW-1:0]  cy_reg;
    logic signed [ZW-1:0]  z_reg;
    logic [NW-1:0]         rem_reg;
    logic [COORD_BITS-1:0] root_reg;
    logic signed [CW-1:0]  cx_next;
    logic signed [CW-1:0]  cy_next;
    logic signed [ZW-1:0]  z_next;
    logic [NW-1:0]         rem_next;
    logic [COORD_BITS-1:0] root_next;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic                  pos;

    always_comb
    begin
        dx  = cy_in >>> IDX;
        dy  = cx_in >>> IDX;
        pos = (cy_in > 0);
        if (pos)
        begin
            cx_next = cx_in + dx;
            cy_next = cy_in - dy;
            z_next  = z_in + ATAN_STEP;
        end
        else
        begin
            cx_next = cx_in - dx;
            cy_next = cy_in + dy;
            z_next  = z_in - ATAN_STEP;
        end
    end

    generate
        if (IDX < COORD_BITS)
        begin : g_sqrt
            localparam int K = COORD_BITS - 1 - IDX;
            logic [NW:0] trial;
            always_comb
            begin
                trial = ((NW + 1)'(root_in) << (K + 1)) + ((NW + 1)'(1) << (2 * K));
                if ((NW + 1)'(rem_in) >= trial)
                begin
                    rem_next  = rem_in - trial[NW-1:0];
                    root_next = root_in | (COORD_BITS'(1) << K);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end
        end
        else
        begin : g_pass
            assign rem_next  = rem_in;
            assign root_next = root_in;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg <= flags_in;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            z_reg     <= z_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
        end
    end

    assign vld_out   = vld_reg;
    assign flags_out = flags_reg;
    assign cx_out    = cx_reg;
    assign cy_out    = cy_reg;
    assign z_out     = z_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

FILE: hdl/c2p_post.sv
// back stages: radius rounding, angle clamp, unfold and output register
module c2p_post #(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vld_in,
    input  c2p_pkg::quad_t                   flags_in,
    input  logic signed [c2p_pkg::ZW-1:0]    z_in,
    input  logic [2*COORD_BITS-1:0]          rem_in,
    input  logic [COORD_BITS-1:0]            root_in,
    input  logic                             out_stall,
    output logic                             adv,
    output logic                             out_valid,
    output logic [COORD_BITS-1:0]            radius,
    output logic [ANGLE_BITS-1:0]            polar_angle
);
    import c2p_pkg::*;

    localparam int NW  = 2 * COORD_BITS;
    localparam int AW  = 34;
    localparam int ASH = 32 - ANGLE_BITS;
    localparam logic [AW-1:0] RND    = (AW'(1) << ASH) >> 1;
    localparam logic [AW-1:0] C_Q1   = RND;
    localparam logic [AW-1:0] C_HALF = AW'(34'h0_8000_0000) + RND;
    localparam logic [AW-1:0] C_FULL = AW'(34'h1_0000_0000) + RND;

    logic                  vld_a_reg;
    quad_t                 flags_a_reg;
    logic [TW-1:0]         t_a_reg;
    logic [COORD_BITS-1:0] rad_a_reg;
    logic [TW-1:0]         t_next;
    logic [COORD_BITS-1:0] rad_next;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] radius_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [ANGLE_BITS-1:0] angle_next;
    logic [AW-1:0]         full;
    logic [AW-1:0]         t_ext;

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (z_in < 0)
        begin
            t_next = '0;
        end
        else if (z_in > $signed({1'b0, TURN_QUARTER}))
        begin
            t_next = TURN_QUARTER;
        end
        else
        begin
            t_next = z_in[TW-1:0];
        end
        rad_next = (rem_in > NW'(root_in)) ? root_in + 1'b1 : root_in;
    end

    // unfold into the full turn with rounding folded into the base
    always_comb
    begin
        t_ext = AW'(t_a_reg);
        case ({flags_a_reg.xn, flags_a_reg.yn})
            2'b00:   full = C_Q1 + t_ext;
            2'b10:   full = C_HALF - t_ext;
            2'b11:   full = C_HALF + t_ext;
            default: full = C_FULL - t_ext;
        endcase
        angle_next = flags_a_reg.orig ? '0 : full[ASH +: ANGLE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg     <= vld_in;
            out_valid_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_a_reg <= flags_in;
            t_a_reg     <= t_next;
            rad_a_reg   <= rad_next;
            radius_reg  <= rad_a_reg;
            angle_reg   <= angle_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign radius      = radius_reg;
    assign polar_angle = angle_reg;

endmodule

FILE: hdl/cartesian_to_polar.sv
// top level of the cartesian to polar converter
//
// input beat: x_coord, y_coord (signed) with in_valid; held off by in_stall
// output beat: radius (rounded sqrt(x^2+y^2)) and polar_angle (full turn =
// 2^ANGLE_BITS units, counterclockwise from +x) with out_valid / out_stall
// stages from an accepted input beat to out_valid:
//   3 front stages (fold, squares, sum), 32 cordic cells (the first COORD_BITS
//   also doing one square root digit), 1 rounding stage, 1 output register
// throughput: one beat per cycle unless out_stall freezes the row, set by the row
//   of 32 cells that each take a new point every clock
// the origin gives radius 0 and angle 0
// when out_stall holds a full output register the whole row freezes and
//   in_stall goes high in the same cycle; nothing is dropped
// reset clears every valid bit; no beat is in flight afterwards
module cartesian_to_polar #(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS-1:0]        radius,
    output logic [ANGLE_BITS-1:0]        polar_angle
);
    import c2p_pkg::*;

    localparam int NW = 2 * COORD_BITS;

    logic                  adv;
    logic                  vld_w   [0:N_ITER];
    quad_t                 flags_w [0:N_ITER];
    logic signed [CW-1:0]  cx_w    [0:N_ITER];
    logic signed [CW-1:0]  cy_w    [0:N_ITER];
    logic signed [ZW-1:0]  z_w     [0:N_ITER];
    logic [NW-1:0]         rem_w   [0:N_ITER];
    logic [COORD_BITS-1:0] root_w  [0:N_ITER];

    assign in_stall = !adv;
    assign z_w[0]    = '0;
    assign root_w[0] = '0;

    c2p_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (in_valid),
        .x_in      (x_coord),
        .y_in      (y_coord),
        .vld_out   (vld_w[0]),
        .flags_out (flags_w[0]),
        .n_out     (rem_w[0]),
        .cx_out    (cx_w[0]),
        .cy_out    (cy_w[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < N_ITER; gi++)
        begin : g_cell
            c2p_cell #(
                .COORD_BITS (COORD_BITS),
                .IDX        (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .vld_in    (vld_w[gi]),
                .flags_in  (flags_w[gi]),
                .cx_in     (cx_w[gi]),
                .cy_in     (cy_w[gi]),
                .z_in      (z_w[gi]),
                .rem_in    (rem_w[gi]),
                .root_in   (root_w[gi]),
                .vld_out   (vld_w[gi+1]),
                .flags_out (flags_w[gi+1]),
                .cx_out    (cx_w[gi+1]),
                .cy_out    (cy_w[gi+1]),
                .z_out     (z_w[gi+1]),
                .rem_out   (rem_w[gi+1]),
                .root_out  (root_w[gi+1])
            );
        end
    endgenerate

    c2p_post #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .vld_in      (vld_w[N_ITER]),
        .flags_in    (flags_w[N_ITER]),
        .z_in        (z_w[N_ITER]),
        .rem_in      (rem_w[N_ITER]),
        .root_in     (root_w[N_ITER]),
        .out_stall   (out_stall),
        .adv         (adv),
        .out_valid   (out_valid),
        .radius      (radius),
        .polar_angle (polar_angle)
    );

    // cx and cy of the last cell are not needed past the row
    logic unused_tail;
    assign unused_tail = ^{cx_w[N_ITER], cy_w[N_ITER]};

endmodule

FILE: dv/tb_cartesian_to_polar.sv
// self-checking testbench for the cartesian to polar converter
`timescale 1ns / 100ps

module tb_cartesian_to_polar;

    localparam int CB = 16;
    localparam int AB = 16;
    localparam int LIMIT = 300000;
    localparam int DRAIN = 60;
    localparam int RANDOM_POINTS = 2000;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 250;
    localparam longint QUARTER_TURN = 64'h4000_0000;
    localparam logic [63:0] HALF_TURN = 64'h8000_0000;
    localparam logic [63:0] FULL_TURN = 64'h1_0000_0000;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } point_t;

    typedef struct packed {
        logic [CB-1:0] radius;
        logic [AB-1:0] angle;
    } polar_t;

    typedef struct packed {
        point_t pt;
        polar_t want;
    } conv_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CB-1:0] x_coord;
    logic signed [CB-1:0] y_coord;
    logic                 out_valid;
    logic                 out_stall;
    logic [CB-1:0]        radius;
    logic [AB-1:0]        polar_angle;

    point_t pending_pts[$];
    conv_t  expected_polar[$];

    int  n_errors = 0;
    int  n_taken = 0;
    int  n_points = 0;
    int  cycle_cnt = 0;
    bit  beat_taken = 0;
    int  burst_left = 8;
    int  gap_left = 0;
    int  phase_left = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    cartesian_to_polar #(
        .COORD_BITS(CB),
        .ANGLE_BITS(AB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .radius(radius),
        .polar_angle(polar_angle)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_coord = '0;
        y_coord = '0;
        out_stall = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CB-1:0] round_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        if (n - root * root > root)
            root = root + 1;
        return root[CB-1:0];
    endfunction

    // vectoring rotations, angle in 2^-32 turn, clamped to a quarter turn
    function automatic logic [63:0] first_quadrant_angle(input logic [63:0] ax,
                                                         input logic [63:0] ay);
        logic [63:0]        cx;
        logic [63:0]        dy;
        logic signed [63:0] cy;
        logic signed [63:0] dx;
        longint             z;
        cx = ax << (61 - CB);
        cy = ay << (61 - CB);
        z = 0;
        for (int i = 0; i < 32; i++)
        begin
            dx = cy >>> i;
            dy = cx >> i;
            if (cy > 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + longint'(ATAN_TURN[i]);
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - longint'(ATAN_TURN[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > QUARTER_TURN)
            z = QUARTER_TURN;
        return z;
    endfunction

    function automatic polar_t to_polar(input point_t p);
        longint      xv;
        longint      yv;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] t;
        logic [63:0] turn;
        polar_t      r;
        xv = p.x;
        yv = p.y;
        ax = (xv < 0) ? -xv : xv;
        ay = (yv < 0) ? -yv : yv;
        r.radius = round_sqrt(ax * ax + ay * ay);
        if (ax == 0 && ay == 0)
            r.angle = '0;
        else
        begin
            t = first_quadrant_angle(ax, ay);
            if (xv >= 0 && yv >= 0)
                turn = t;
            else if (xv < 0 && yv >= 0)
                turn = HALF_TURN - t;
            else if (xv < 0)
                turn = HALF_TURN + t;
            else
                turn = FULL_TURN - t;
            turn = (turn + (64'd1 << (31 - AB))) >> (32 - AB);
            r.angle = turn[AB-1:0];
        end
        return r;
    endfunction

    task automatic add_point(input int xi, input int yi);
        point_t p;
        p.x = xi[CB-1:0];
        p.y = yi[CB-1:0];
        pending_pts.push_back(p);
        n_points++;
    endtask

    // sender: bursts of beats separated by idle gaps of varying length, sometimes none
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_stall_hold())
            begin
                if (beat_taken)
                begin
                    void'(pending_pts.pop_front());
                    beat_taken = 0;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pts.size() > 0)
                begin
                    x_coord <= pending_pts[0].x;
                    y_coord <= pending_pts[0].y;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // true while the beat on the input is still waiting to be taken
    function automatic bit in_stall_hold();
        return in_valid && !beat_taken;
    endfunction

    // receiver: stall phases of varying density plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && n_taken >= HOLD_AFTER)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (phase_left <= 0)
                begin
                    phase_left = $urandom_range(20, 120);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 20;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // monitor: predict accepted input beats, check accepted output beats
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_polar.size() == 0)
                begin
                    $display("%0t: unexpected beat: radius %0d angle %0d",
                             $time, radius, polar_angle);
                    n_errors++;
                end
                else
                begin
                    conv_t e;
                    e = expected_polar.pop_front();
                    if (radius !== e.want.radius)
                    begin
                        $display("%0t: radius of (%0d,%0d): expected %0d, actual %0d",
                                 $time, e.pt.x, e.pt.y, e.want.radius, radius);
                        n_errors++;
                    end
                    if (polar_angle !== e.want.angle)
                    begin
                        $display("%0t: angle of (%0d,%0d): expected %0d, actual %0d",
                                 $time, e.pt.x, e.pt.y, e.want.angle, polar_angle);
                        n_errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                conv_t c;
                c.pt.x = x_coord;
                c.pt.y = y_coord;
                c.want = to_polar(c.pt);
                expected_polar.push_back(c);
                beat_taken = 1;
                n_taken++;
            end
        end
    end

    initial
    begin
        int sel;
        int m;
        int a;
        int b;
        // origin, axes, extremes, diagonals, angles close to the wrap
        add_point(0, 0);
        add_point(1, 0);
        add_point(-1, 0);
        add_point(0, 1);
        add_point(0, -1);
        add_point(32767, 0);
        add_point(-32768, 0);
        add_point(0, 32767);
        add_point(0, -32768);
        add_point(32767, 32767);
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(-32768, 32767);
        add_point(1, 1);
        add_point(-1, -1);
        add_point(1, -1);
        add_point(-1, 1);
        add_point(32767, -1);
        add_point(100, -1);
        add_point(-32768, -1);
        add_point(-32768, 1);
        add_point(3, 4);
        add_point(-5, 12);
        for (int k = 0; k < RANDOM_POINTS; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                add_point($urandom, $urandom);
            else if (sel < 70)
                add_point(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8);
            else if (sel < 85)
            begin
                m = $signed(16'($urandom));
                case ($urandom_range(0, 3))
                    0: add_point(m, 0);
                    1: add_point(0, m);
                    2: add_point(m, m);
                    default: add_point(m, -m);
                endcase
            end
            else
            begin
                a = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 2))
                                         : -32768 + int'($urandom_range(0, 2));
                b = $urandom;
                if ($urandom_range(0, 1))
                    add_point(a, b);
                else
                    add_point(b, a);
            end
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (n_taken < n_points)
            @(posedge clk);
        while (expected_polar.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
hdl/c2p_pkg.sv
hdl/c2p_prep.sv
hdl/c2p_cell.sv
hdl/c2p_post.sv
hdl/cartesian_to_polar.sv
dv/tb_cartesian_to_polar.sv
